>>> design/ste_pkg.sv
// shared constants, types and state encodings of the symbol name token expander
package ste_pkg;

   // table and name limits
   localparam int TOKEN_COUNT       = 256;
   localparam int TOKEN_STORE_BYTES = 4096;
   localparam int MAX_TOKEN_LEN     = 32;
   localparam int NAME_LEN_LIMIT    = 512;

   // derived widths
   localparam int TOK_IDX_W    = $clog2(TOKEN_COUNT);
   localparam int TOK_NUM_W    = $clog2(TOKEN_COUNT + 1);
   localparam int STORE_ADDR_W = $clog2(TOKEN_STORE_BYTES);
   localparam int STORE_PTR_W  = $clog2(TOKEN_STORE_BYTES + 1);
   localparam int TOK_LEN_W    = $clog2(MAX_TOKEN_LEN + 1);
   localparam int NAME_LEN_W   = $clog2(NAME_LEN_LIMIT);
   localparam int IDX_CMP_W    = 9;

   // two-byte length format
   localparam logic [7:0] LEN_LOW_MASK = 8'h7F;
   localparam int         LEN_SHIFT    = 7;
   localparam int         LEN_RAW_W    = 15;
   localparam int         LEN_CMP_W    = 16;

   // front to back queue
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   // input action codes
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_NAMES = 1'b1;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_EXPAND  = 2'd1,
      OP_BAD_LEN = 2'd2
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       first;
      logic       final_idx;
   } entry_type;

   typedef enum logic [1:0] {
      KIND_TYPE    = 2'd0,
      KIND_NAME    = 2'd1,
      KIND_END     = 2'd2,
      KIND_BAD_LEN = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_LEN1 = 2'd0,
      PH_LEN2 = 2'd1,
      PH_IDX  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      BK_IDLE   = 3'd0,
      BK_LOOKUP = 3'd1,
      BK_CHAR   = 3'd2,
      BK_TYPE0  = 3'd3,
      BK_END    = 3'd4,
      BK_ERR    = 3'd5
   } back_state_type;

endpackage

>>> design/ste_front.sv
// front end: accepts input transfers, parses name lengths and classifies queue entries
module ste_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tuser,
   input  logic                queue_full,
   output logic                push_valid,
   output ste_pkg::entry_type  push_entry
);

   ste_pkg::phase_type                phase_ff, phase_in;
   logic [6:0]                        low_ff, low_in;
   logic [ste_pkg::NAME_LEN_W-1:0]    left_ff, left_in;
   logic                              first_ff, first_in;

   logic                              accept;
   logic                              names;
   logic [ste_pkg::LEN_RAW_W-1:0]     len_two;
   logic [ste_pkg::LEN_RAW_W-1:0]     len_sel;
   logic                              len_ok;
   logic                              final_idx;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && !queue_full;
   assign names      = (req_tuser == ste_pkg::ACTION_NAMES);

   assign len_two = (ste_pkg::LEN_RAW_W'(req_tdata) << ste_pkg::LEN_SHIFT)
                    | ste_pkg::LEN_RAW_W'(low_ff);
   assign len_sel = (phase_ff == ste_pkg::PH_LEN2) ? len_two
                                                   : ste_pkg::LEN_RAW_W'(req_tdata);
   assign len_ok  = (len_sel != '0) &&
                    (ste_pkg::LEN_CMP_W'(len_sel) < ste_pkg::LEN_CMP_W'(ste_pkg::NAME_LEN_LIMIT));
   assign final_idx = (left_ff == ste_pkg::NAME_LEN_W'(1));

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept && names) begin
         unique case (phase_ff)
            ste_pkg::PH_LEN2: phase_in = len_ok ? ste_pkg::PH_IDX : ste_pkg::PH_LEN1;
            ste_pkg::PH_IDX:  phase_in = final_idx ? ste_pkg::PH_LEN1 : ste_pkg::PH_IDX;
            default: begin
               if (req_tdata[7]) begin
                  phase_in = ste_pkg::PH_LEN2;
               end else if (len_ok) begin
                  phase_in = ste_pkg::PH_IDX;
               end else begin
                  phase_in = ste_pkg::PH_LEN1;
               end
            end
         endcase
      end
   end

   // queue entry and length bookkeeping
   always_comb begin
      push_valid           = 1'b0;
      push_entry.op        = ste_pkg::OP_LOAD;
      push_entry.data      = req_tdata;
      push_entry.first     = first_ff;
      push_entry.final_idx = final_idx;
      low_in               = low_ff;
      left_in              = left_ff;
      first_in             = first_ff;
      if (accept) begin
         if (!names) begin
            push_valid = 1'b1;
         end else begin
            unique case (phase_ff)
               ste_pkg::PH_IDX: begin
                  push_valid    = 1'b1;
                  push_entry.op = ste_pkg::OP_EXPAND;
                  left_in       = left_ff - 1'b1;
                  first_in      = 1'b0;
               end
               ste_pkg::PH_LEN2: begin
                  if (len_ok) begin
                     left_in  = len_sel[ste_pkg::NAME_LEN_W-1:0];
                     first_in = 1'b1;
                  end else begin
                     push_valid    = 1'b1;
                     push_entry.op = ste_pkg::OP_BAD_LEN;
                  end
               end
               default: begin
                  if (req_tdata[7]) begin
                     low_in = 7'(req_tdata & ste_pkg::LEN_LOW_MASK);
                  end else if (len_ok) begin
                     left_in  = len_sel[ste_pkg::NAME_LEN_W-1:0];
                     first_in = 1'b1;
                  end else begin
                     push_valid    = 1'b1;
                     push_entry.op = ste_pkg::OP_BAD_LEN;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ste_pkg::PH_LEN1;
         low_ff   <= '0;
         left_ff  <= '0;
         first_ff <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         low_ff   <= low_in;
         left_ff  <= left_in;
         first_ff <= first_in;
      end
   end

endmodule

>>> design/ste_queue.sv
// short first-in first-out queue of classified entries between front and back
module ste_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  ste_pkg::entry_type  push_entry,
   output logic                full,
   output logic                head_valid,
   output ste_pkg::entry_type  head_entry,
   input  logic                pop
);

   ste_pkg::entry_type                 slot_ff [ste_pkg::QUEUE_DEPTH];
   logic [ste_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [ste_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [ste_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                               do_push, do_pop;

   assign full       = (count_ff == ste_pkg::QUEUE_CNT_W'(ste_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> design/ste_back.sv
// back end: token table loading, token expansion and the result register
module ste_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  ste_pkg::entry_type  head_entry,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser,
   output logic                rsp_tlast
);

   ste_pkg::back_state_type            state_ff, state_in;

   // token table stores
   logic [7:0]                         byte_mem  [ste_pkg::TOKEN_STORE_BYTES];
   logic [ste_pkg::STORE_ADDR_W-1:0]   start_mem [ste_pkg::TOKEN_COUNT];
   logic [ste_pkg::TOK_LEN_W-1:0]      len_mem   [ste_pkg::TOKEN_COUNT];
   logic [ste_pkg::TOKEN_COUNT-1:0]    len_valid_ff;

   // load state
   logic [ste_pkg::STORE_PTR_W-1:0]    wp_ff, wp_in;
   logic [ste_pkg::TOK_NUM_W-1:0]      tok_num_ff, tok_num_in;
   logic [ste_pkg::TOK_LEN_W-1:0]      cur_len_ff, cur_len_in;
   logic                               ovf_ff, ovf_in;
   logic                               byte_we, start_we, len_we;

   // lookup and read
   logic                               lookup_re;
   logic [ste_pkg::STORE_ADDR_W-1:0]   start_rd_ff;
   logic [ste_pkg::TOK_LEN_W-1:0]      len_rd_ff;
   logic                               valid_rd_ff;
   logic                               range_ok_ff;
   logic                               range_ok;
   logic [ste_pkg::TOK_LEN_W-1:0]      eff_len;
   logic                               byte_re;
   logic [ste_pkg::STORE_ADDR_W-1:0]   byte_raddr;
   logic [7:0]                         byte_rd_ff;

   // current entry
   logic                               first_ff, first_in;
   logic                               final_ff, final_in;
   logic [ste_pkg::TOK_LEN_W-1:0]      tok_len_ff, tok_len_in;
   logic [ste_pkg::TOK_LEN_W-1:0]      cnt_ff, cnt_in;
   logic [ste_pkg::TOK_LEN_W-1:0]      cnt_next;
   logic [ste_pkg::STORE_ADDR_W-1:0]   addr_ff, addr_in;
   logic                               more;

   // result register
   logic                               out_valid_ff, out_valid_in;
   ste_pkg::kind_type                  kind_ff;
   logic [7:0]                         char_ff;
   logic                               last_ff;
   logic                               ovf_out_ff;
   logic                               slot_free;
   logic                               emit;
   ste_pkg::kind_type                  emit_kind;
   logic [7:0]                         emit_char;
   logic                               emit_last;

   assign slot_free = !out_valid_ff || rsp_tready;
   assign range_ok  = (ste_pkg::IDX_CMP_W'(head_entry.data)
                       < ste_pkg::IDX_CMP_W'(ste_pkg::TOKEN_COUNT));
   assign eff_len   = (range_ok_ff && valid_rd_ff) ? len_rd_ff : '0;
   assign cnt_next  = cnt_ff + 1'b1;
   assign more      = (cnt_next != tok_len_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ste_pkg::BK_IDLE: begin
            if (head_valid) begin
               if (head_entry.op == ste_pkg::OP_EXPAND) begin
                  state_in = ste_pkg::BK_LOOKUP;
               end else if (head_entry.op == ste_pkg::OP_BAD_LEN) begin
                  state_in = ste_pkg::BK_ERR;
               end
            end
         end
         ste_pkg::BK_LOOKUP: begin
            if (eff_len != '0) begin
               state_in = ste_pkg::BK_CHAR;
            end else if (first_ff) begin
               state_in = ste_pkg::BK_TYPE0;
            end else if (final_ff) begin
               state_in = ste_pkg::BK_END;
            end else begin
               state_in = ste_pkg::BK_IDLE;
            end
         end
         ste_pkg::BK_CHAR: begin
            if (slot_free && !more) begin
               state_in = final_ff ? ste_pkg::BK_END : ste_pkg::BK_IDLE;
            end
         end
         ste_pkg::BK_TYPE0: begin
            if (slot_free) begin
               state_in = final_ff ? ste_pkg::BK_END : ste_pkg::BK_IDLE;
            end
         end
         ste_pkg::BK_END, ste_pkg::BK_ERR: begin
            if (slot_free) begin
               state_in = ste_pkg::BK_IDLE;
            end
         end
         default: state_in = ste_pkg::BK_IDLE;
      endcase
   end

   // datapath controls
   always_comb begin
      pop        = 1'b0;
      byte_we    = 1'b0;
      start_we   = 1'b0;
      len_we     = 1'b0;
      wp_in      = wp_ff;
      tok_num_in = tok_num_ff;
      cur_len_in = cur_len_ff;
      ovf_in     = ovf_ff;
      lookup_re  = 1'b0;
      byte_re    = 1'b0;
      byte_raddr = addr_ff;
      first_in   = first_ff;
      final_in   = final_ff;
      tok_len_in = tok_len_ff;
      cnt_in     = cnt_ff;
      addr_in    = addr_ff;
      emit       = 1'b0;
      emit_kind  = ste_pkg::KIND_NAME;
      emit_char  = 8'd0;
      emit_last  = 1'b0;
      unique case (state_ff)
         ste_pkg::BK_IDLE: begin
            if (head_valid) begin
               pop      = 1'b1;
               first_in = head_entry.first;
               final_in = head_entry.final_idx;
               if (head_entry.op == ste_pkg::OP_EXPAND) begin
                  lookup_re = 1'b1;
               end else if (head_entry.op == ste_pkg::OP_LOAD) begin
                  if (tok_num_ff >= ste_pkg::TOK_NUM_W'(ste_pkg::TOKEN_COUNT)) begin
                     ovf_in = 1'b1;
                  end else begin
                     start_we = (cur_len_ff == '0);
                     if (head_entry.data == 8'd0) begin
                        len_we     = 1'b1;
                        tok_num_in = tok_num_ff + 1'b1;
                        cur_len_in = '0;
                     end else if ((cur_len_ff >= ste_pkg::TOK_LEN_W'(ste_pkg::MAX_TOKEN_LEN)) ||
                        (wp_ff >= ste_pkg::STORE_PTR_W'(ste_pkg::TOKEN_STORE_BYTES))) begin
                        ovf_in = 1'b1;
                     end else begin
                        byte_we    = 1'b1;
                        wp_in      = wp_ff + 1'b1;
                        cur_len_in = cur_len_ff + 1'b1;
                     end
                  end
               end
            end
         end
         ste_pkg::BK_LOOKUP: begin
            tok_len_in = eff_len;
            cnt_in     = '0;
            addr_in    = start_rd_ff;
            byte_raddr = start_rd_ff;
            byte_re    = (eff_len != '0);
         end
         ste_pkg::BK_CHAR: begin
            if (slot_free) begin
               emit      = 1'b1;
               emit_kind = (cnt_ff == '0 && first_ff) ? ste_pkg::KIND_TYPE
                                                      : ste_pkg::KIND_NAME;
               emit_char = byte_rd_ff;
               emit_last = !more && !final_ff;
               if (more) begin
                  byte_re    = 1'b1;
                  byte_raddr = addr_ff + 1'b1;
                  addr_in    = addr_ff + 1'b1;
                  cnt_in     = cnt_next;
               end
            end
         end
         ste_pkg::BK_TYPE0: begin
            emit      = slot_free;
            emit_kind = ste_pkg::KIND_TYPE;
            emit_last = !final_ff;
         end
         ste_pkg::BK_END: begin
            emit      = slot_free;
            emit_kind = ste_pkg::KIND_END;
            emit_last = 1'b1;
         end
         ste_pkg::BK_ERR: begin
            emit      = slot_free;
            emit_kind = ste_pkg::KIND_BAD_LEN;
            emit_last = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // token stores, registered reads
   always_ff @(posedge clock) begin
      if (byte_we) begin
         byte_mem[wp_ff[ste_pkg::STORE_ADDR_W-1:0]] <= head_entry.data;
      end
      if (byte_re) begin
         byte_rd_ff <= byte_mem[byte_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (start_we) begin
         start_mem[tok_num_ff[ste_pkg::TOK_IDX_W-1:0]] <= wp_ff[ste_pkg::STORE_ADDR_W-1:0];
      end
      if (lookup_re) begin
         start_rd_ff <= start_mem[head_entry.data[ste_pkg::TOK_IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[tok_num_ff[ste_pkg::TOK_IDX_W-1:0]] <= cur_len_ff;
      end
      if (lookup_re) begin
         len_rd_ff   <= len_mem[head_entry.data[ste_pkg::TOK_IDX_W-1:0]];
         valid_rd_ff <= len_valid_ff[head_entry.data[ste_pkg::TOK_IDX_W-1:0]];
         range_ok_ff <= range_ok;
      end
   end

   // entries with no length written read as length zero
   always_ff @(posedge clock) begin
      if (reset) begin
         len_valid_ff <= '0;
      end else if (len_we) begin
         len_valid_ff[tok_num_ff[ste_pkg::TOK_IDX_W-1:0]] <= 1'b1;
      end
   end

   // result payload and current entry registers
   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff    <= emit_kind;
         char_ff    <= emit_char;
         last_ff    <= emit_last;
         ovf_out_ff <= ovf_ff;
      end
      first_ff   <= first_in;
      final_ff   <= final_in;
      tok_len_ff <= tok_len_in;
      cnt_ff     <= cnt_in;
      addr_ff    <= addr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ste_pkg::BK_IDLE;
         wp_ff        <= '0;
         tok_num_ff   <= '0;
         cur_len_ff   <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         tok_num_ff   <= tok_num_in;
         cur_len_ff   <= cur_len_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, ovf_out_ff, char_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

>>> design/symbol_name_token_expander.sv
// top level of the symbol name token expander
//
// The block takes a token table and then a stream of compressed symbol names
// on one input channel. req_tuser low loads the table: NUL-terminated tokens,
// one per token number, stored at most MAX_TOKEN_LEN characters each into a
// TOKEN_STORE_BYTES store; anything that does not fit is dropped and raises
// the sticky table_overflow flag. req_tuser high carries the names: a length
// byte (two bytes when bit 7 is set: low 7 bits plus the second byte times
// 128), then that many token index bytes. Each index expands to its token's
// characters; the first character of a name is marked as the symbol type,
// an empty first token gives one type result with a zero character, and an
// end result follows the last index. A zero length or one at or above
// NAME_LEN_LIMIT gives one bad-length result. rsp_tlast marks the final
// result caused by one input transfer. A front end parses lengths and hands
// entries through a four-deep queue to a back end that owns the token
// stores. A bad length gives its error result; an index does a start/length
// lookup (registered memory read), then reads its characters out of the
// token store, or gives a type result for an empty first token, and the last
// index is followed by the end result. A stalled result port holds the back
// end while the front end keeps filling the queue.
module symbol_name_token_expander (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tuser,    // [0] action: 0 table load, 1 names stream
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // [7:0] out_char, [8] table_overflow, rest zero
   output logic [1:0]  rsp_tuser,    // [1:0] kind
   output logic        rsp_tlast     // last result of the input transfer
);

   // front to queue
   logic                queue_full;
   logic                push_valid;
   ste_pkg::entry_type  push_entry;

   // queue to back
   logic                head_valid;
   ste_pkg::entry_type  head_entry;
   logic                pop;

   // length parsing and classification
   ste_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // decouples parsing from expansion
   ste_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   // table store, expansion and result register
   ste_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
